// ===== rtl/fbmp_pkg.sv =====
package fbmp_pkg;

  // Fixed-point layout
  localparam int FRAC_BITS  = 16;
  localparam int AMP_FRAC   = 14;
  localparam int LAC_FRAC   = 12;
  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int VAL_W      = 8;

  // Datapath widths
  localparam int COORD_W = 32;
  localparam int MUL_W   = 34;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int FADE_W  = FRAC_BITS + 2;
  localparam int NOISE_W = FRAC_BITS + 4;
  localparam int R_W     = 25;
  localparam int WT_W    = 32;
  localparam int AMP_W   = 28;
  localparam int ASUM_W  = 33;
  localparam int SUM_W   = 64;
  localparam int OFF_SHL = FRAC_BITS - LAC_FRAC;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OCT_CFG_W  = 4;

  // Stream payload layout
  localparam int S_TDATA_W = 2 * VAL_W + 3 * COORD_W;
  localparam int M_TDATA_W = 32;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  localparam logic signed [MUL_W-1:0] ONE_FX    = MUL_W'(1) <<< FRAC_BITS;
  localparam logic signed [MUL_W-1:0] FADE_A    = MUL_W'(6);
  localparam logic signed [MUL_W-1:0] FADE_B_FX = MUL_W'(15) <<< FRAC_BITS;
  localparam logic signed [MUL_W-1:0] FADE_C_FX = MUL_W'(10) <<< FRAC_BITS;

  localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(1) << AMP_FRAC;
  localparam logic [AMP_W-1:0] AMP_CAP = '1;
  localparam logic [WT_W-1:0]  WT_CAP  = '1;
  localparam logic [R_W-1:0]   R_ONE   = R_W'(1) << FRAC_BITS;

  // Gradient hash selects
  localparam logic [3:0] H_U_FROM_Y = 4'd8;
  localparam logic [3:0] H_V_FROM_Z = 4'd4;
  localparam logic [3:0] H_V_X_LO   = 4'd12;
  localparam logic [3:0] H_V_X_HI   = 4'd14;
  localparam logic [3:0] H_MASK     = 4'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OCTAVE_COUNT = 3'd0,
    CFG_OCTAVE_GAIN  = 3'd1,
    CFG_LACUNARITY   = 3'd2,
    CFG_RIDGED_MODE  = 3'd3,
    CFG_RIDGE_OFFSET = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CALC,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  typedef enum logic [4:0] {
    S_FX0, S_FX1, S_FX2, S_FX3,
    S_FY0, S_FY1, S_FY2, S_FY3,
    S_FZ0, S_FZ1, S_FZ2, S_FZ3,
    S_BX0, S_BX1, S_BX2, S_BX3,
    S_BY0, S_BY1, S_BY2, S_BZ,
    S_NOISE, S_TERM, S_WEIGHT, S_SCALE, S_ACC,
    S_AMP, S_LX, S_LY, S_LZ
  } step_e;

  function automatic logic signed [NOISE_W-1:0] grad(
    input logic [3:0]               h,
    input logic signed [FADE_W-1:0] gx,
    input logic signed [FADE_W-1:0] gy,
    input logic signed [FADE_W-1:0] gz
  );
    logic [3:0]               hm;
    logic signed [FADE_W-1:0] u;
    logic signed [FADE_W-1:0] v;
    logic signed [NOISE_W-1:0] su;
    logic signed [NOISE_W-1:0] sv;
    hm = h & H_MASK;
    u  = (hm < H_U_FROM_Y) ? gx : gy;
    v  = (hm < H_V_FROM_Z) ? gy : ((hm == H_V_X_LO || hm == H_V_X_HI) ? gx : gz);
    su = hm[0] ? -NOISE_W'(u) : NOISE_W'(u);
    sv = hm[1] ? -NOISE_W'(v) : NOISE_W'(v);
    return su + sv;
  endfunction

endpackage

// ===== rtl/fbmp_ram.sv =====
module fbmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fbm_perlin_noise_3d.sv =====
// Fractal (fBm or ridged fBm) 3D gradient noise at a Q16.16 point. A load transfer
// (tuser = 0) writes one byte of the 256-entry permutation table; the table
// has no reset, so load every entry before evaluating. An evaluate transfer
// (tuser = 1) runs each octave as table reads on the single RAM read port
// followed by 29 steps through one shared 34x34 multiplier; after the last
// octave a restoring divider does the amplitude normalization and the result
// is handed off. The block takes one evaluate at a time; loads and new
// requests are taken while a result waits in the output register.
module fbm_perlin_noise_3d
  import fbmp_pkg::*;
#(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // perm_index, perm_value, x_coord, y_coord, z_coord
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // req_type
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // noise_value
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int OCT_W   = $clog2(MAX_OCTAVES + 1);
  localparam int FETCH_N = 14;
  localparam int FCNT_W  = 4;
  localparam int DCNT_W  = $clog2(SUM_W);

  // Configuration
  logic [OCT_CFG_W-1:0]  octave_count_q, octave_count_d;
  logic [CFG_DATA_W-1:0] octave_gain_q, octave_gain_d;
  logic [CFG_DATA_W-1:0] lacunarity_q, lacunarity_d;
  logic                  ridged_mode_q, ridged_mode_d;
  logic [CFG_DATA_W-1:0] ridge_offset_q, ridge_offset_d;

  // Control
  state_e              state_q, state_d;
  step_e               step_q, step_d;
  logic [FCNT_W-1:0]   fetch_cnt_q, fetch_cnt_d;
  logic [DCNT_W-1:0]   div_cnt_q, div_cnt_d;
  logic [OCT_W-1:0]    oct_k_q, oct_k_d;
  logic [OCT_W-1:0]    oct_total_q, oct_total_d;
  logic                out_valid_q, out_valid_d;

  // Payload
  logic signed [COORD_W-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [VAL_W-1:0]          rd_q [FETCH_N];
  logic [VAL_W-1:0]          rd_d [FETCH_N];
  logic signed [FADE_W-1:0]  u_q, u_d, v_q, v_d, w_q, w_d;
  logic signed [NOISE_W-1:0] l_q [4];
  logic signed [NOISE_W-1:0] l_d [4];
  logic signed [NOISE_W-1:0] m0_q, m0_d, m1_q, m1_d, n_q, n_d;
  logic [R_W-1:0]            r_q, r_d, prev_q, prev_d;
  logic [AMP_W-1:0]          amp_q, amp_d;
  logic [ASUM_W-1:0]         asum_q, asum_d;
  logic signed [SUM_W-1:0]   fsum_q, fsum_d;
  logic [SUM_W-1:0]          rsum_q, rsum_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic [ASUM_W-1:0]         rem_q, rem_d;
  logic [SUM_W-1:0]          quo_q, quo_d;
  logic                      neg_q, neg_d;
  logic [M_TDATA_W-1:0]      out_data_q, out_data_d;

  // Combinational helpers
  logic                      s_accept, m_accept, out_free, oct_last;
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_raddr;
  logic [VAL_W-1:0]          ram_rdata;
  logic [IDX_W-1:0]          cx, cy, cz, aa, ab, ba, bb;
  logic signed [FADE_W-1:0]  fxs, fys, fzs, gxs, gys, gzs;
  logic signed [NOISE_W-1:0] g [8];
  logic signed [PROD_W-1:0]  p16;
  logic signed [MUL_W-1:0]   mul_a, mul_b, ft, dd;
  logic [NOISE_W-1:0]        n_abs;
  logic [R_W-1:0]            r_c;
  logic [WT_W-1:0]           wt_c;
  logic [PROD_W-1:0]         amp_c;
  logic [ASUM_W:0]           rem_sh;
  logic                      div_ge;
  logic [SUM_W-1:0]          fsum_mag;
  logic [OCT_CFG_W:0]        oct_ext, oct_clamp;
  logic [M_TDATA_W-1:0]      sat_res;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign m_accept = out_valid_q && m_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign oct_last = (OCT_W'(oct_k_q + 1'b1) == oct_total_q);

  fbmp_ram #(
    .WIDTH(VAL_W),
    .DEPTH(TABLE_SIZE)
  ) u_perm_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(s_axis_tdata[IDX_W-1:0]),
    .wdata_i(s_axis_tdata[VAL_W +: VAL_W]),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Configuration writes
  always_comb begin
    octave_count_d = octave_count_q;
    octave_gain_d  = octave_gain_q;
    lacunarity_d   = lacunarity_q;
    ridged_mode_d  = ridged_mode_q;
    ridge_offset_d = ridge_offset_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OCTAVE_COUNT: octave_count_d = cfg_wdata_i[OCT_CFG_W-1:0];
        CFG_OCTAVE_GAIN:  octave_gain_d  = cfg_wdata_i;
        CFG_LACUNARITY:   lacunarity_d   = cfg_wdata_i;
        CFG_RIDGED_MODE:  ridged_mode_d  = cfg_wdata_i[0];
        CFG_RIDGE_OFFSET: ridge_offset_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (s_accept && s_axis_tuser == REQ_EVAL) state_d = ST_FETCH;
      ST_FETCH:  if (fetch_cnt_q == FCNT_W'(FETCH_N)) state_d = ST_CALC;
      ST_CALC: begin
        if (step_q == S_LZ) state_d = oct_last ? ST_DIVIDE : ST_FETCH;
      end
      ST_DIVIDE: if (div_cnt_q == DCNT_W'(SUM_W - 1)) state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Handshake and table port
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    ram_we        = s_accept && (s_axis_tuser == REQ_LOAD);
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Cell and hash addresses
  assign cx = x_q[FRAC_BITS +: IDX_W];
  assign cy = y_q[FRAC_BITS +: IDX_W];
  assign cz = z_q[FRAC_BITS +: IDX_W];
  assign aa = IDX_W'(rd_q[2] + cz);
  assign ab = IDX_W'(rd_q[3] + cz);
  assign ba = IDX_W'(rd_q[4] + cz);
  assign bb = IDX_W'(rd_q[5] + cz);

  always_comb begin
    unique case (fetch_cnt_q)
      4'd0:    ram_raddr = cx;
      4'd1:    ram_raddr = IDX_W'(cx + 1'b1);
      4'd2:    ram_raddr = IDX_W'(rd_q[0] + cy);
      4'd3:    ram_raddr = IDX_W'(rd_q[0] + cy + 1'b1);
      4'd4:    ram_raddr = IDX_W'(rd_q[1] + cy);
      4'd5:    ram_raddr = IDX_W'(rd_q[1] + cy + 1'b1);
      4'd6:    ram_raddr = aa;
      4'd7:    ram_raddr = ba;
      4'd8:    ram_raddr = ab;
      4'd9:    ram_raddr = bb;
      4'd10:   ram_raddr = IDX_W'(aa + 1'b1);
      4'd11:   ram_raddr = IDX_W'(ba + 1'b1);
      4'd12:   ram_raddr = IDX_W'(ab + 1'b1);
      4'd13:   ram_raddr = IDX_W'(bb + 1'b1);
      default: ram_raddr = cx;
    endcase
  end

  // Corner offsets and gradients
  assign fxs = $signed({{(FADE_W-FRAC_BITS){1'b0}}, x_q[FRAC_BITS-1:0]});
  assign fys = $signed({{(FADE_W-FRAC_BITS){1'b0}}, y_q[FRAC_BITS-1:0]});
  assign fzs = $signed({{(FADE_W-FRAC_BITS){1'b0}}, z_q[FRAC_BITS-1:0]});
  assign gxs = fxs - FADE_W'(ONE_FX);
  assign gys = fys - FADE_W'(ONE_FX);
  assign gzs = fzs - FADE_W'(ONE_FX);

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      g[c] = grad(rd_q[6 + c][3:0],
                  c[0] ? gxs : fxs,
                  c[1] ? gys : fys,
                  c[2] ? gzs : fzs);
    end
  end

  // Shared multiplier operands
  assign p16   = prod_q >>> FRAC_BITS;
  assign n_abs = n_q[NOISE_W-1] ? NOISE_W'(-n_q) : NOISE_W'(n_q);
  assign dd    = MUL_W'({ridge_offset_q, {OFF_SHL{1'b0}}}) - MUL_W'(n_abs);
  assign r_c   = R_W'(p16);
  assign wt_c  = (p16 > $signed(PROD_W'(WT_CAP))) ? WT_CAP : WT_W'(p16);
  assign amp_c = PROD_W'(prod_q >>> AMP_FRAC);

  always_comb begin
    unique case (step_q)
      S_FX0, S_FX1, S_FX2, S_FX3: ft = MUL_W'(fxs);
      S_FY0, S_FY1, S_FY2, S_FY3: ft = MUL_W'(fys);
      default:                    ft = MUL_W'(fzs);
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_q)
      S_FX0, S_FY0, S_FZ0: begin
        mul_a = ft;
        mul_b = ft * FADE_A - FADE_B_FX;
      end
      S_FX1, S_FY1, S_FZ1: begin
        mul_a = MUL_W'(p16) + FADE_C_FX;
        mul_b = ft;
      end
      S_FX2, S_FY2, S_FZ2, S_FX3, S_FY3, S_FZ3: begin
        mul_a = MUL_W'(p16);
        mul_b = ft;
      end
      S_BX0: begin mul_a = MUL_W'(u_q); mul_b = MUL_W'(g[1]) - MUL_W'(g[0]); end
      S_BX1: begin mul_a = MUL_W'(u_q); mul_b = MUL_W'(g[3]) - MUL_W'(g[2]); end
      S_BX2: begin mul_a = MUL_W'(u_q); mul_b = MUL_W'(g[5]) - MUL_W'(g[4]); end
      S_BX3: begin mul_a = MUL_W'(u_q); mul_b = MUL_W'(g[7]) - MUL_W'(g[6]); end
      S_BY0: begin mul_a = MUL_W'(v_q); mul_b = MUL_W'(l_q[1]) - MUL_W'(l_q[0]); end
      S_BY1: begin mul_a = MUL_W'(v_q); mul_b = MUL_W'(l_q[3]) - MUL_W'(l_q[2]); end
      S_BZ:  begin mul_a = MUL_W'(w_q); mul_b = MUL_W'(m1_q) - MUL_W'(m0_q); end
      S_TERM: begin
        if (ridged_mode_q) begin
          mul_a = dd;
          mul_b = dd;
        end else begin
          mul_a = MUL_W'(n_q);
          mul_b = $signed({{(MUL_W-AMP_W){1'b0}}, amp_q});
        end
      end
      S_WEIGHT: begin
        mul_a = $signed({{(MUL_W-R_W){1'b0}}, r_c});
        mul_b = $signed({{(MUL_W-R_W){1'b0}}, prev_q});
      end
      S_SCALE: begin
        mul_a = $signed({{(MUL_W-WT_W){1'b0}}, wt_c});
        mul_b = $signed({{(MUL_W-AMP_W){1'b0}}, amp_q});
      end
      S_ACC: begin
        mul_a = $signed({{(MUL_W-AMP_W){1'b0}}, amp_q});
        mul_b = $signed({{(MUL_W-CFG_DATA_W){1'b0}}, octave_gain_q});
      end
      S_AMP: begin
        mul_a = MUL_W'(x_q);
        mul_b = $signed({{(MUL_W-CFG_DATA_W){1'b0}}, lacunarity_q});
      end
      S_LX: begin
        mul_a = MUL_W'(y_q);
        mul_b = $signed({{(MUL_W-CFG_DATA_W){1'b0}}, lacunarity_q});
      end
      S_LY: begin
        mul_a = MUL_W'(z_q);
        mul_b = $signed({{(MUL_W-CFG_DATA_W){1'b0}}, lacunarity_q});
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Divider and output saturation
  assign rem_sh   = {rem_q, quo_q[SUM_W-1]};
  assign div_ge   = (rem_sh >= {1'b0, asum_q});
  assign fsum_mag = fsum_q[SUM_W-1] ? SUM_W'(-fsum_q) : SUM_W'(fsum_q);

  always_comb begin
    if (neg_q) begin
      if (quo_q > (SUM_W'(1) << (M_TDATA_W - 1))) begin
        sat_res = {1'b1, {(M_TDATA_W-1){1'b0}}};
      end else begin
        sat_res = M_TDATA_W'(-quo_q[M_TDATA_W-1:0]);
      end
    end else begin
      if (quo_q > SUM_W'({1'b0, {(M_TDATA_W-1){1'b1}}})) begin
        sat_res = {1'b0, {(M_TDATA_W-1){1'b1}}};
      end else begin
        sat_res = quo_q[M_TDATA_W-1:0];
      end
    end
  end

  assign oct_ext   = {1'b0, octave_count_q};
  assign oct_clamp = (oct_ext == '0) ? (OCT_CFG_W+1)'(1) :
                     (oct_ext > (OCT_CFG_W+1)'(MAX_OCTAVES)) ? (OCT_CFG_W+1)'(MAX_OCTAVES) :
                     oct_ext;

  // Datapath and sequencing
  always_comb begin
    step_d      = step_q;
    fetch_cnt_d = fetch_cnt_q;
    div_cnt_d   = div_cnt_q;
    oct_k_d     = oct_k_q;
    oct_total_d = oct_total_q;
    out_valid_d = out_valid_q;
    x_d = x_q; y_d = y_q; z_d = z_q;
    rd_d = rd_q;
    u_d = u_q; v_d = v_q; w_d = w_q;
    l_d = l_q;
    m0_d = m0_q; m1_d = m1_q; n_d = n_q;
    r_d = r_q; prev_d = prev_q;
    amp_d = amp_q; asum_d = asum_q;
    fsum_d = fsum_q; rsum_d = rsum_q;
    rem_d = rem_q; quo_d = quo_q; neg_d = neg_q;
    out_data_d = out_data_q;

    if (m_accept) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_accept && s_axis_tuser == REQ_EVAL) begin
          x_d         = s_axis_tdata[2*VAL_W +: COORD_W];
          y_d         = s_axis_tdata[2*VAL_W + COORD_W +: COORD_W];
          z_d         = s_axis_tdata[2*VAL_W + 2*COORD_W +: COORD_W];
          amp_d       = AMP_ONE;
          asum_d      = '0;
          fsum_d      = '0;
          rsum_d      = '0;
          prev_d      = R_ONE;
          oct_k_d     = '0;
          oct_total_d = OCT_W'(oct_clamp);
          fetch_cnt_d = '0;
          step_d      = S_FX0;
        end
      end
      ST_FETCH: begin
        // Data for the address issued in the cycle before
        if (fetch_cnt_q != '0) rd_d[FCNT_W'(fetch_cnt_q - 1'b1)] = ram_rdata;
        fetch_cnt_d = FCNT_W'(fetch_cnt_q + 1'b1);
      end
      ST_CALC: begin
        step_d = step_e'(step_q + 1'b1);
        unique case (step_q)
          S_FY0:    u_d = FADE_W'(p16);
          S_FZ0:    v_d = FADE_W'(p16);
          S_BX0:    w_d = FADE_W'(p16);
          S_BX1:    l_d[0] = g[0] + NOISE_W'(p16);
          S_BX2:    l_d[1] = g[2] + NOISE_W'(p16);
          S_BX3:    l_d[2] = g[4] + NOISE_W'(p16);
          S_BY0:    l_d[3] = g[6] + NOISE_W'(p16);
          S_BY1:    m0_d = l_q[0] + NOISE_W'(p16);
          S_BY2:    m1_d = l_q[2] + NOISE_W'(p16);
          S_NOISE:  n_d = m0_q + NOISE_W'(p16);
          S_WEIGHT: begin
            if (!ridged_mode_q) fsum_d = fsum_q + SUM_W'(prod_q);
            r_d = r_c;
          end
          S_ACC: begin
            if (ridged_mode_q) begin
              rsum_d = rsum_q + SUM_W'(prod_q);
              prev_d = r_q;
            end
            asum_d = asum_q + ASUM_W'(amp_q);
          end
          S_AMP: amp_d = (amp_c > PROD_W'(AMP_CAP)) ? AMP_CAP : AMP_W'(amp_c);
          S_LX:  x_d = prod_q[LAC_FRAC +: COORD_W];
          S_LY:  y_d = prod_q[LAC_FRAC +: COORD_W];
          S_LZ: begin
            z_d         = prod_q[LAC_FRAC +: COORD_W];
            step_d      = S_FX0;
            fetch_cnt_d = '0;
            oct_k_d     = OCT_W'(oct_k_q + 1'b1);
            quo_d       = ridged_mode_q ? rsum_q : fsum_mag;
            neg_d       = !ridged_mode_q && fsum_q[SUM_W-1];
            rem_d       = '0;
            div_cnt_d   = '0;
          end
          default: ;
        endcase
      end
      ST_DIVIDE: begin
        rem_d     = div_ge ? ASUM_W'(rem_sh - {1'b0, asum_q}) : ASUM_W'(rem_sh);
        quo_d     = {quo_q[SUM_W-2:0], div_ge};
        div_cnt_d = DCNT_W'(div_cnt_q + 1'b1);
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = sat_res;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octave_count_q <= OCT_CFG_W'(4);
      octave_gain_q  <= CFG_DATA_W'(8192);
      lacunarity_q   <= CFG_DATA_W'(8192);
      ridged_mode_q  <= 1'b0;
      ridge_offset_q <= CFG_DATA_W'(4096);
      state_q        <= ST_IDLE;
      step_q         <= S_FX0;
      fetch_cnt_q    <= '0;
      div_cnt_q      <= '0;
      oct_k_q        <= '0;
      oct_total_q    <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      octave_count_q <= octave_count_d;
      octave_gain_q  <= octave_gain_d;
      lacunarity_q   <= lacunarity_d;
      ridged_mode_q  <= ridged_mode_d;
      ridge_offset_q <= ridge_offset_d;
      state_q        <= state_d;
      step_q         <= step_d;
      fetch_cnt_q    <= fetch_cnt_d;
      div_cnt_q      <= div_cnt_d;
      oct_k_q        <= oct_k_d;
      oct_total_q    <= oct_total_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    z_q        <= z_d;
    rd_q       <= rd_d;
    u_q        <= u_d;
    v_q        <= v_d;
    w_q        <= w_d;
    l_q        <= l_d;
    m0_q       <= m0_d;
    m1_q       <= m1_d;
    n_q        <= n_d;
    r_q        <= r_d;
    prev_q     <= prev_d;
    amp_q      <= amp_d;
    asum_q     <= asum_d;
    fsum_q     <= fsum_d;
    rsum_q     <= rsum_d;
    prod_q     <= prod_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    neg_q      <= neg_d;
    out_data_q <= out_data_d;
  end

endmodule

// ===== rtl/fbmp_checker.sv =====
module fbmp_checker
  import fbmp_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // An evaluate occupies the block
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_EVAL |=> !s_axis_tready)
    else $error("input taken during an evaluate");

  // Table loads never stall the input
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_LOAD |=> s_axis_tready)
    else $error("load stalled the input");

  // A new result only comes out of a busy period
  a_out_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without an evaluate in flight");

endmodule

bind fbm_perlin_noise_3d fbmp_checker u_fbmp_checker (.*);

// ===== test/tb_fbm_perlin_noise_3d.sv =====
`timescale 1ns / 1ps

module tb_fbm_perlin_noise_3d;
  import fbmp_pkg::*;

  localparam longint ONE = 64'sd65536;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // perm_index, perm_value, x_coord, y_coord, z_coord
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  // req_type
  logic                  s_axis_tuser = REQ_LOAD;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // noise_value
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  fbm_perlin_noise_3d uut (.*);

  always #2 clk_i = ~clk_i;

  // Shadow state of the block
  bit [7:0]  perm_tbl [TABLE_SIZE];
  bit [3:0]  sh_octaves = 4'd4;
  bit [15:0] sh_gain = 16'd8192;
  bit [15:0] sh_lac = 16'd8192;
  bit        sh_ridged = 1'b0;
  bit [15:0] sh_offset = 16'd4096;

  logic [31:0] noise_q[$];
  int n_err = 0, n_eval = 0, n_load = 0, n_seen = 0;
  bit no_idle = 1'b0;

  function automatic longint perm_at(longint i);
    return longint'(perm_tbl[i & 255]);
  endfunction

  function automatic longint fade_fx(longint t);
    longint i, f;
    i = ((t * (6 * t - 15 * ONE)) >>> 16) + 10 * ONE;
    f = (i * t) >>> 16;
    f = (f * t) >>> 16;
    return (f * t) >>> 16;
  endfunction

  function automatic longint lerp_fx(longint t, longint a, longint b);
    return a + ((t * (b - a)) >>> 16);
  endfunction

  function automatic longint corner_grad(longint hash, longint x, longint y, longint z);
    bit [3:0] h;
    longint u, v;
    h = hash[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic longint gradient_noise(longint x, longint y, longint z);
    longint cx, cy, cz, fx, fy, fz, gx, gy, gz, u, v, w;
    longint a, aa, ab, b, ba, bb, n0, n1;
    cx = (x >>> 16) & 255;
    cy = (y >>> 16) & 255;
    cz = (z >>> 16) & 255;
    fx = x & (ONE - 1);
    fy = y & (ONE - 1);
    fz = z & (ONE - 1);
    u = fade_fx(fx);
    v = fade_fx(fy);
    w = fade_fx(fz);
    a = perm_at(cx) + cy;
    aa = perm_at(a) + cz;
    ab = perm_at(a + 1) + cz;
    b = perm_at(cx + 1) + cy;
    ba = perm_at(b) + cz;
    bb = perm_at(b + 1) + cz;
    gx = fx - ONE;
    gy = fy - ONE;
    gz = fz - ONE;
    n0 = lerp_fx(v,
      lerp_fx(u, corner_grad(perm_at(aa), fx, fy, fz), corner_grad(perm_at(ba), gx, fy, fz)),
      lerp_fx(u, corner_grad(perm_at(ab), fx, gy, fz), corner_grad(perm_at(bb), gx, gy, fz)));
    n1 = lerp_fx(v,
      lerp_fx(u, corner_grad(perm_at(aa + 1), fx, fy, gz),
                 corner_grad(perm_at(ba + 1), gx, fy, gz)),
      lerp_fx(u, corner_grad(perm_at(ab + 1), fx, gy, gz),
                 corner_grad(perm_at(bb + 1), gx, gy, gz)));
    return lerp_fx(w, n0, n1);
  endfunction

  function automatic logic [31:0] fractal_noise(logic [31:0] xi, logic [31:0] yi,
                                                logic [31:0] zi);
    longint x, y, z, n, d, fsum, res, off;
    longint unsigned amp, asum, rsum, prev, r, wt;
    int oct;
    x = longint'(signed'(xi));
    y = longint'(signed'(yi));
    z = longint'(signed'(zi));
    amp = 64'd1 << AMP_FRAC;
    asum = 0;
    rsum = 0;
    fsum = 0;
    prev = 64'd65536;
    off = longint'(sh_offset) << 4;
    oct = sh_octaves;
    if (oct == 0) oct = 1;
    if (oct > 8) oct = 8;
    for (int k = 0; k < oct; k++) begin
      n = gradient_noise(x, y, z);
      if (sh_ridged) begin
        d = off - ((n < 0) ? -n : n);
        r = longint'(d * d) >> 16;
        wt = (r * prev) >> 16;
        if (wt > 64'hFFFF_FFFF) wt = 64'hFFFF_FFFF;
        rsum += wt * amp;
        prev = r;
      end else begin
        fsum += n * longint'(amp);
      end
      asum += amp;
      amp = (amp * sh_gain) >> AMP_FRAC;
      if (amp > 64'h0FFF_FFFF) amp = 64'h0FFF_FFFF;
      x = longint'(int'((x * longint'(sh_lac)) >>> 12));
      y = longint'(int'((y * longint'(sh_lac)) >>> 12));
      z = longint'(int'((z * longint'(sh_lac)) >>> 12));
    end
    res = sh_ridged ? longint'(rsum / asum) : fsum / longint'(asum);
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res[31:0];
  endfunction

  // Drive one request; update the shadow state when the transfer happens
  task automatic send_req(logic req, logic [7:0] idx, logic [7:0] val,
                          logic [31:0] x, logic [31:0] y, logic [31:0] z,
                          bit fixed_exp, logic [31:0] exp_v);
    while (!no_idle && $urandom_range(99) < 38) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = req;
    s_axis_tdata = {z, y, x, val, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (req == REQ_LOAD) begin
      perm_tbl[idx] = val;
      n_load++;
    end else begin
      noise_q.push_back(fixed_exp ? exp_v : fractal_noise(x, y, z));
      n_eval++;
    end
    @(negedge clk_i);
  endtask

  // Hold off until every result is back, then let the block settle
  task automatic drain;
    s_axis_tvalid = 1'b0;
    while (noise_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_OCTAVE_COUNT: sh_octaves = val[3:0];
      CFG_OCTAVE_GAIN:  sh_gain = val;
      CFG_LACUNARITY:   sh_lac = val;
      CFG_RIDGED_MODE:  sh_ridged = val[0];
      CFG_RIDGE_OFFSET: sh_offset = val;
      default: ;
    endcase
  endtask

  always @(negedge clk_i) m_axis_tready <= no_idle || ($urandom_range(99) >= 38);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_seen++;
      if (noise_q.size() == 0) begin
        $display("%0t: noise_value expected none actual %h", $time, m_axis_tdata);
        n_err++;
      end else if (noise_q[0] !== m_axis_tdata) begin
        $display("%0t: noise_value expected %h actual %h", $time, noise_q[0], m_axis_tdata);
        n_err++;
        void'(noise_q.pop_front());
      end else begin
        void'(noise_q.pop_front());
      end
    end
  end

  typedef struct {
    logic        req;
    logic [7:0]  idx;
    logic [7:0]  val;
    logic [31:0] x, y, z;
    bit          fixed_exp;
    logic [31:0] exp_v;
  } dir_row_t;

  // Directed evaluates and loads; integer lattice points give zero noise at every octave (lacunarity 2.0)
  dir_row_t dir_rows[] = '{
    '{REQ_EVAL, 8'h00, 8'h00, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0},
    '{REQ_EVAL, 8'h00, 8'h00, 32'h0005_0000, 32'hFFFD_0000, 32'h0064_0000, 1'b1, 32'h0},
    '{REQ_EVAL, 8'h00, 8'h00, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{REQ_EVAL, 8'h00, 8'h00, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0},
    '{REQ_EVAL, 8'h00, 8'h00, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 32'h0},
    '{REQ_EVAL, 8'h00, 8'h00, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 1'b0, 32'h0},
    '{REQ_EVAL, 8'h00, 8'h00, 32'h1234_5678, 32'hDEAD_BEEF, 32'h0BAD_F00D, 1'b0, 32'h0},
    '{REQ_LOAD, 8'h00, 8'hFF, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
    '{REQ_LOAD, 8'hFF, 8'h00, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
    '{REQ_LOAD, 8'h80, 8'hAA, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
    '{REQ_EVAL, 8'h00, 8'h00, 32'hFFFF_0000, 32'h00FF_4000, 32'h80FF_C000, 1'b0, 32'h0},
    '{REQ_EVAL, 8'h00, 8'h00, 32'h00FF_FFFF, 32'hFF00_0001, 32'h0001_7777, 1'b0, 32'h0}
  };

  typedef struct {
    logic [3:0]  oct;
    logic [15:0] gain, lac;
    logic        ridged;
    logic [15:0] off;
    bit          burst;
  } setting_t;

  setting_t settings[] = '{
    '{4'd1,  16'd65535, 16'd65535, 1'b0, 16'd0,     1'b0},
    '{4'd8,  16'd0,     16'd0,     1'b1, 16'd65535, 1'b0},
    '{4'd0,  16'd16384, 16'd4096,  1'b1, 16'd4096,  1'b0},
    '{4'd15, 16'd8192,  16'd8192,  1'b0, 16'd4096,  1'b1},
    '{4'd3,  16'd12000, 16'd9000,  1'b1, 16'd6000,  1'b0},
    '{4'd2,  16'd32768, 16'd0,     1'b1, 16'd0,     1'b0},
    '{4'd6,  16'd65535, 16'd65535, 1'b1, 16'd65535, 1'b0}
  };

  initial begin
    logic [7:0]  shuf [256];
    logic [7:0]  tmp;
    logic [31:0] c [3];
    int j;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Fill the whole table with a shuffled permutation before any evaluate
    for (int i = 0; i < 256; i++) shuf[i] = i[7:0];
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = shuf[i];
      shuf[i] = shuf[j];
      shuf[j] = tmp;
    end
    for (int i = 0; i < 256; i++)
      send_req(REQ_LOAD, i[7:0], shuf[i], 32'h0, 32'h0, 32'h0, 1'b0, 32'h0);

    foreach (dir_rows[i])
      send_req(dir_rows[i].req, dir_rows[i].idx, dir_rows[i].val, dir_rows[i].x,
               dir_rows[i].y, dir_rows[i].z, dir_rows[i].fixed_exp, dir_rows[i].exp_v);

    foreach (settings[p]) begin
      drain();
      write_reg(CFG_OCTAVE_COUNT, {12'h0, settings[p].oct});
      write_reg(CFG_OCTAVE_GAIN, settings[p].gain);
      write_reg(CFG_LACUNARITY, settings[p].lac);
      write_reg(CFG_RIDGED_MODE, {15'h0, settings[p].ridged});
      write_reg(CFG_RIDGE_OFFSET, settings[p].off);
      no_idle = settings[p].burst;
      repeat (175) begin
        for (int k = 0; k < 3; k++)
          c[k] = ($urandom_range(1) == 0) ? $urandom() : 32'($signed($urandom_range(2097152))
                                                             - 1048576);
        if ($urandom_range(99) < 35)
          send_req(REQ_LOAD, 8'($urandom()), 8'($urandom()), c[0], c[1], c[2], 1'b0, 32'h0);
        else
          send_req(REQ_EVAL, 8'($urandom()), 8'($urandom()), c[0], c[1], c[2], 1'b0, 32'h0);
      end
      no_idle = 1'b0;
    end

    drain();
    repeat (500) @(negedge clk_i);
    $display("Covered %0d evaluates and %0d table loads over %0d register settings,",
             n_eval, n_load, settings.size() + 1);
    $display("plain and ridged sums, octave counts 0 to 15, gain and scale extremes.");
    if (n_err == 0 && n_seen == n_eval) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
